>>> hdl/nes_pad_poller_with_register_read_defines.svh
// Assertion macros for the pad poller.
// Included by the top level; no other dependencies.
`ifndef NES_PAD_POLLER_WITH_REGISTER_READ_DEFINES_SVH
`define NES_PAD_POLLER_WITH_REGISTER_READ_DEFINES_SVH

`ifndef ASSERT_OFF
`define NPP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define NPP_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define NPP_ASSERT(lbl, clk, rstn, prop)
`define NPP_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

>>> hdl/npp_pkg.sv
// Shared constants and types of the pad poller.
// No dependencies.
package npp_pkg;

    localparam int NUM_PADS     = 2;
    localparam int BITS_PER_PAD = 8;
    localparam int PAD_W        = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int BIT_W        = $clog2(BITS_PER_PAD);
    localparam int LINE_W       = 2;
    localparam int TICK_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 8;

    localparam logic [TICK_W-1:0] PULSE_RESET = 16'd12;
    localparam logic [BYTE_W-1:0] BAD_INDEX_BYTE = 8'hFF;
    localparam logic [BIT_W-1:0]  LAST_BIT = BIT_W'(BITS_PER_PAD - 1);
    localparam logic [IDX_W-1:0]  PAD_COUNT = IDX_W'(NUM_PADS);
    localparam logic [PAD_W-1:0]  LAST_PAD = PAD_W'(NUM_PADS - 1);

    localparam logic [1:0] PH_LATCH_HI = 2'd0;
    localparam logic [1:0] PH_LATCH_LO = 2'd1;
    localparam logic [1:0] PH_CLOCK_HI = 2'd2;
    localparam logic [1:0] PH_CLOCK_LO = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic [LINE_W-1:0] clock_lines;
        logic [LINE_W-1:0] latch_lines;
    } npp_res_t;

endpackage

>>> hdl/npp_seq.sv
// Pin sequencer and per-pad byte store; one item per accepted step.
// Depends on npp_pkg.
module npp_seq
    import npp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              cmd,
    input  logic              data_level,
    input  logic [IDX_W-1:0]  reg_index,
    input  logic [TICK_W-1:0] pulse_ticks,
    output npp_res_t          res
);

    logic [1:0]        phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [PAD_W-1:0]  pad_reg, pad_next;
    logic [BYTE_W-1:0] bytes_reg [NUM_PADS];
    logic              store;
    logic [TICK_W-1:0] len;
    logic              level_done;
    logic [LINE_W-1:0] pad_bit;
    logic [BYTE_W-1:0] shifted;

    assign len        = (pulse_ticks == '0) ? TICK_W'(1) : pulse_ticks;
    assign level_done = ({1'b0, tick_reg} + (TICK_W+1)'(1)) >= {1'b0, len};
    // pads past the line width shift out and show no line
    assign pad_bit    = LINE_W'(1) << pad_reg;
    assign shifted    = {shift_reg[BYTE_W-2:0], data_level};

    always_comb begin
        res.latch_lines = (phase_reg == PH_LATCH_HI) ? pad_bit : '0;
        res.clock_lines = (phase_reg == PH_CLOCK_HI) ? pad_bit : '0;
        if (cmd == CMD_READ) begin
            res.read_valid = 1'b1;
            if (reg_index < PAD_COUNT) begin
                res.read_data = bytes_reg[reg_index[PAD_W-1:0]];
            end else begin
                res.read_data = BAD_INDEX_BYTE;
            end
        end else begin
            res.read_valid = 1'b0;
            res.read_data  = '0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pad_next   = pad_reg;
        store      = 1'b0;
        if (cmd == CMD_TICK) begin
            if (!level_done) begin
                tick_next = tick_reg + TICK_W'(1);
            end else begin
                tick_next = '0;
                case (phase_reg)
                    PH_LATCH_HI: begin
                        phase_next = PH_LATCH_LO;
                    end
                    PH_LATCH_LO: begin
                        shift_next = {{(BYTE_W-1){1'b0}}, data_level};
                        bit_next   = '0;
                        phase_next = PH_CLOCK_HI;
                    end
                    PH_CLOCK_HI: begin
                        phase_next = PH_CLOCK_LO;
                    end
                    default: begin
                        shift_next = shifted;
                        bit_next   = bit_reg + BIT_W'(1);
                        if (bit_reg + BIT_W'(1) >= LAST_BIT) begin
                            store      = 1'b1;
                            pad_next   = (pad_reg == LAST_PAD) ? '0 : pad_reg + PAD_W'(1);
                            bit_next   = '0;
                            phase_next = PH_LATCH_HI;
                        end else begin
                            phase_next = PH_CLOCK_HI;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LATCH_HI;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pad_reg   <= '0;
            for (int i = 0; i < NUM_PADS; i++) begin
                bytes_reg[i] <= '0;
            end
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pad_reg   <= pad_next;
            if (store) begin
                bytes_reg[pad_reg] <= shifted;
            end
        end
    end

endmodule

>>> hdl/nes_pad_poller_with_register_read.sv
// Top level of the pad poller: stream ports, pulse length register, output buffer.
// Depends on npp_pkg, npp_seq and the assertion macro header.
//
// Polls the gamepads round robin: latch high and low, then a clock pulse per later
// bit, each level held pulse_ticks ticks (0 counts as 1), one data bit taken at the
// end of every low level, MSB first. Every input item yields one result: a tick
// item advances the sequencer by one tick and reports the line levels; a read
// item returns the stored byte of pad reg_index (255 past the last pad) without
// advancing. One item per cycle while s_tready is high; results are registered, and
// a skid stage holds one more result so s_tready stays high until it fills.
`include "nes_pad_poller_with_register_read_defines.svh"

module nes_pad_poller_with_register_read
    import npp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] data_level, [8:1] reg_index
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] latch_lines, [3:2] clock_lines, [11:4] read_data
    output logic [0:0]  m_tuser,   // [0] read_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [TICK_W-1:0] pulse_reg;
    logic              s_acc, m_take;
    npp_res_t          res;
    npp_res_t          out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign m_take    = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg <= PULSE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            pulse_reg <= cfg_data;
        end
    end

    npp_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_acc),
        .cmd         (s_tuser[0]),
        .data_level  (s_tdata[0]),
        .reg_index   (s_tdata[IDX_W:1]),
        .pulse_ticks (pulse_reg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_acc) begin
            if (!out_valid_reg || m_take) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.read_data, out_reg.clock_lines, out_reg.latch_lines};
    assign m_tuser  = out_reg.read_valid;

    `NPP_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `NPP_ASSERT(a_tick_no_data, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata[11:4] == 8'd0))
    `NPP_ASSERT(a_one_line, aclk, aresetn, m_tvalid |-> $onehot0(m_tdata[3:0]))
    `NPP_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_take, !skid_valid_reg)

endmodule

>>> sim/nes_pad_poller_with_register_read_tb.sv
// Self-checking testbench for the pad poller: directed table, then random tick/read items.
// Depends on npp_pkg and nes_pad_poller_with_register_read; results are checked
// against an in-bench model of the poll sequencer.
`timescale 1ns / 1ps

module nes_pad_poller_with_register_read_tb;
    import npp_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int N_PHASES     = 7;
    localparam int DIR_ROWS     = 24;

    localparam int unsigned PULSE_PLAN [N_PHASES] = '{1, 12, 2, 65535, 0, 3, 1};
    localparam int unsigned PLAN_ITEMS [N_PHASES] = '{110, 90, 80, 30, 100, 50, 40};

    typedef struct packed {
        logic              cmd;
        logic              lvl;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        npp_res_t          res;
    } dir_row_t;

    // first rows right after reset: all stored bytes zero, pad 0 latch high
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{CMD_READ, 1'b0, 8'd0,   1'b1, '{1'b1, 8'h00, 2'b00, 2'b01}},
        '{CMD_READ, 1'b0, 8'd1,   1'b1, '{1'b1, 8'h00, 2'b00, 2'b01}},
        '{CMD_READ, 1'b0, 8'd2,   1'b1, '{1'b1, 8'hFF, 2'b00, 2'b01}},
        '{CMD_READ, 1'b1, 8'd255, 1'b1, '{1'b1, 8'hFF, 2'b00, 2'b01}},
        '{CMD_TICK, 1'b1, 8'd255, 1'b1, '{1'b0, 8'h00, 2'b00, 2'b01}},
        '{CMD_TICK, 1'b1, 8'd0,   1'b0, '0},
        '{CMD_TICK, 1'b0, 8'h55,  1'b0, '0},
        '{CMD_TICK, 1'b0, 8'h01,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'hAA,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'h02,  1'b0, '0},
        '{CMD_TICK, 1'b0, 8'h80,  1'b0, '0},
        '{CMD_TICK, 1'b0, 8'h7F,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'h10,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'h20,  1'b0, '0},
        '{CMD_TICK, 1'b0, 8'h40,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'h04,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'h08,  1'b0, '0},
        '{CMD_TICK, 1'b0, 8'hFE,  1'b0, '0},
        '{CMD_TICK, 1'b0, 8'h0F,  1'b0, '0},
        '{CMD_TICK, 1'b1, 8'hF0,  1'b0, '0},
        '{CMD_READ, 1'b0, 8'd0,   1'b0, '0},
        '{CMD_READ, 1'b1, 8'd1,   1'b0, '0},
        '{CMD_TICK, 1'b0, 8'd1,   1'b0, '0},
        '{CMD_READ, 1'b0, 8'h80,  1'b0, '0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [0] data_level, [8:1] reg_index
    logic [0:0]  s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] latch_lines, [3:2] clock_lines, [11:4] read_data
    logic [0:0]  m_tuser;   // [0] read_valid
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    nes_pad_poller_with_register_read i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // poll sequencer state as seen by the bench
    logic [TICK_W-1:0] pulse_len;
    logic [BYTE_W-1:0] pad_bytes [NUM_PADS];
    logic [PAD_W-1:0]  cur_pad;
    logic [1:0]        poll_phase;
    logic [TICK_W-1:0] tick_cnt;
    logic [BIT_W-1:0]  bit_cnt;
    logic [BYTE_W-1:0] shift_reg;

    npp_res_t pending_results [$];
    int       mismatch_count = 0;
    int       results_seen   = 0;
    int       tick_items     = 0;
    int       read_items     = 0;
    bit       tail_quiet     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic npp_res_t poll_step(input logic cmd, input logic lvl,
                                           input logic [IDX_W-1:0] idx);
        npp_res_t          r;
        logic [LINE_W-1:0] pad_mask;
        logic [TICK_W:0]   hold;
        pad_mask      = LINE_W'(1) << cur_pad;
        r.latch_lines = (poll_phase == PH_LATCH_HI) ? pad_mask : '0;
        r.clock_lines = (poll_phase == PH_CLOCK_HI) ? pad_mask : '0;
        if (cmd == CMD_READ) begin
            r.read_valid = 1'b1;
            r.read_data  = (idx < PAD_COUNT) ? pad_bytes[idx[PAD_W-1:0]] : BAD_INDEX_BYTE;
            return r;
        end
        r.read_valid = 1'b0;
        r.read_data  = '0;
        hold = (pulse_len == '0) ? (TICK_W+1)'(1) : {1'b0, pulse_len};
        if ({1'b0, tick_cnt} + 1 < hold) begin
            tick_cnt = tick_cnt + 1'b1;
            return r;
        end
        tick_cnt = '0;
        case (poll_phase)
            PH_LATCH_HI: begin
                poll_phase = PH_LATCH_LO;
            end
            PH_LATCH_LO: begin
                shift_reg  = BYTE_W'(lvl);
                bit_cnt    = '0;
                poll_phase = PH_CLOCK_HI;
            end
            PH_CLOCK_HI: begin
                poll_phase = PH_CLOCK_LO;
            end
            default: begin
                shift_reg = {shift_reg[BYTE_W-2:0], lvl};
                bit_cnt   = bit_cnt + 1'b1;
                if (bit_cnt >= LAST_BIT) begin
                    pad_bytes[cur_pad] = shift_reg;
                    cur_pad    = (cur_pad == LAST_PAD) ? '0 : cur_pad + 1'b1;
                    bit_cnt    = '0;
                    poll_phase = PH_LATCH_HI;
                end else begin
                    poll_phase = PH_CLOCK_HI;
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_count++;
        $display("[%0t] result %0d %s: expected 0x%0h, got 0x%0h",
                 $time, results_seen, field, want, got);
    endtask

    task automatic send_item(input logic cmd, input logic lvl, input logic [IDX_W-1:0] idx,
                             input logic typed, input npp_res_t typed_res);
        npp_res_t want;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16-1-IDX_W){1'b0}}, idx, lvl};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        want = poll_step(cmd, lvl, idx);
        if (typed) want = typed_res;
        pending_results.push_back(want);
        if (cmd == CMD_READ) read_items++;
        else tick_items++;
        if (!tail_quiet && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_pulse(input logic [TICK_W-1:0] value);
        wait_drained();
        repeat (2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pulse_len = value;
    endtask

    // result side: random stall bursts, none in the tail
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (tail_quiet || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        npp_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", 16'h0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.latch_lines)
                    flag_mismatch("latch_lines", 16'(want.latch_lines), 16'(m_tdata[1:0]));
                if (m_tdata[3:2] !== want.clock_lines)
                    flag_mismatch("clock_lines", 16'(want.clock_lines), 16'(m_tdata[3:2]));
                if (m_tdata[11:4] !== want.read_data)
                    flag_mismatch("read_data", 16'(want.read_data), 16'(m_tdata[11:4]));
                if (m_tuser[0] !== want.read_valid)
                    flag_mismatch("read_valid", 16'(want.read_valid), 16'(m_tuser[0]));
                if (m_tdata[15:12] !== 4'h0)
                    flag_mismatch("m_tdata padding", 16'h0, 16'(m_tdata[15:12]));
            end
        end
    end

    initial begin
        int               k;
        int               p;
        int               n;
        logic             cmd;
        logic [IDX_W-1:0] idx;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        pulse_len  = PULSE_RESET;
        for (k = 0; k < NUM_PADS; k++) pad_bytes[k] = '0;
        cur_pad    = '0;
        poll_phase = PH_LATCH_HI;
        tick_cnt   = '0;
        bit_cnt    = '0;
        shift_reg  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero pulse length: one tick per level, so the table walks a whole pad frame
        write_pulse(16'd0);
        for (k = 0; k < DIR_ROWS; k++)
            send_item(DIRECTED_ROWS[k].cmd, DIRECTED_ROWS[k].lvl, DIRECTED_ROWS[k].idx,
                      DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].res);

        for (p = 0; p < N_PHASES; p++) begin
            write_pulse(TICK_W'(PULSE_PLAN[p]));
            if (p == N_PHASES - 1) tail_quiet = 1'b1;
            for (n = 0; n < int'(PLAN_ITEMS[p]); n++) begin
                cmd = ($urandom_range(0, 4) == 0) ? CMD_READ : CMD_TICK;
                if (cmd == CMD_READ && $urandom_range(0, 9) < 7)
                    idx = IDX_W'($urandom_range(0, NUM_PADS));
                else
                    idx = IDX_W'($urandom_range(0, 255));
                send_item(cmd, 1'($urandom_range(0, 1)), idx, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", 16'h0, 16'(pending_results.size()));

        $display("Covered %0d tick and %0d register-read items, %0d results checked,",
                 tick_items, read_items, results_seen);
        $display("pulse lengths 0, 1, 2, 3, 12 and 65535, stalls on both sides.");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/npp_pkg.sv
hdl/npp_seq.sv
hdl/nes_pad_poller_with_register_read.sv
sim/nes_pad_poller_with_register_read_tb.sv
